// ===== src/abstcs_pkg.sv =====
// ----------------------------------------------------------------------------
// abstcs_pkg
// shared types and constants of the abs/tcs brake factor controller: the
// divider request and response words, fixed-point constants, register indexes
// ----------------------------------------------------------------------------
package abstcs_pkg;

    // q16.16 / q0.16 constants
    localparam logic [16:0]        ONE_Q16     = 17'd65536;
    localparam logic signed [31:0] TORQUE_EPS  = 32'sd65;
    localparam logic signed [31:0] SPEED_MIN   = 32'sd196608;
    localparam logic [16:0]        GAIN_OFFSET = 17'd65536;
    localparam logic [4:0]         GAIN_ROUND  = 5'd19;

    // floor(y/5) = (y * RECIP_5) >> 34 for any 32-bit y
    localparam logic signed [32:0] RECIP_5     = 33'sh0CCCCCCCD;
    localparam int                 RECIP_SHIFT = 34;

    // shared multiplier operand width
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // divider geometry
    localparam int DVS_W  = 31;
    localparam int QUO_W  = 64;
    localparam int STEP_W = 7;

    // quotient magnitudes of the speed and torque divisions stay below 2^62
    localparam int               MAG_W      = 62;
    localparam logic [STEP_W-1:0] STEPS_WIDE = STEP_W'(MAG_W);
    // the factor quotient stays below 2^17
    localparam int               FAC_W      = 17;
    localparam logic [STEP_W-1:0] STEPS_FAC  = STEP_W'(FAC_W);

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ABS_EN    = 3'd0,
        REG_TCS_EN    = 3'd1,
        REG_RADIUS    = 3'd2,
        REG_TIME_STEP = 3'd3,
        REG_INERTIA   = 3'd4,
        REG_MAX_TORQ  = 3'd5
    } reg_idx_t;

    // divider request
    typedef struct packed {
        logic              start;
        logic [DVS_W-1:0]  rem_init;
        logic [QUO_W-1:0]  quo_init;
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/abstcs_if.sv =====
// ----------------------------------------------------------------------------
// abstcs_if
// valid/ready channels of the brake factor controller: one wheel tick word in,
// one brake factor word out
// ----------------------------------------------------------------------------
interface abstcs_item_if;
    logic               valid;
    logic               ready;
    logic               in_contact;
    logic signed [31:0] requested_torque;
    logic signed [31:0] slip_ratio;
    logic [30:0]        ideal_slip;
    logic signed [31:0] ground_speed;
    logic signed [31:0] wheel_speed;
    logic [16:0]        brake_factor_now;

    modport source (
        output valid, in_contact, requested_torque, slip_ratio, ideal_slip,
               ground_speed, wheel_speed, brake_factor_now,
        input  ready
    );

    modport sink (
        input  valid, in_contact, requested_torque, slip_ratio, ideal_slip,
               ground_speed, wheel_speed, brake_factor_now,
        output ready
    );
endinterface

interface abstcs_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] brake_factor;
    logic        abs_engaged;
    logic        tcs_engaged;

    modport source (
        output valid, brake_factor, abs_engaged, tcs_engaged,
        input  ready
    );

    modport sink (
        input  valid, brake_factor, abs_engaged, tcs_engaged,
        output ready
    );
endinterface

// ===== src/abs_tcs_brake_factor_controller_core.sv =====
// ----------------------------------------------------------------------------
// abs_tcs_brake_factor_controller_core
// per-wheel anti-lock and traction control brake factor regulator
//
// usage: one word per physics tick arrives on the item channel (valid/ready);
// one result word leaves on the result channel. item.ready is high only while
// the block is idle; a word is taken when valid and ready are both high.
// a tick without ground contact goes straight to the result word. a contact tick
// runs the target speed division; when the abs or tcs correction applies, also
// the torque correction division and, unless the correction clamps the factor,
// the factor division. the next word is taken the cycle after the result word
// leaves. the divisions share one divider, one quotient bit per cycle: 62 steps
// for the target speed, 62 for the torque correction, 17 for the factor; one
// shared 33x33 multiplier serves the gain, target product and torque product.
// stall: the result word holds until result.ready; no new word is taken.
// reset: state and flags clear, configuration takes its defaults, the block
// comes up idle. configuration is written over the apb port; the user must
// write it only while idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module abs_tcs_brake_factor_controller_core (
    input  logic                   clk,
    input  logic                   rst_n,
    abstcs_item_if.sink            item,
    abstcs_result_if.source        result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import abstcs_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_RECIP  = 14'b00000000000010,
        ST_GAIN   = 14'b00000000000100,
        ST_TSTART = 14'b00000000001000,
        ST_TDIV   = 14'b00000000010000,
        ST_ERR    = 14'b00000000100000,
        ST_CMUL   = 14'b00000001000000,
        ST_CSTART = 14'b00000010000000,
        ST_CDIV   = 14'b00000100000000,
        ST_TORQ   = 14'b00001000000000,
        ST_FSEL   = 14'b00010000000000,
        ST_FDIV   = 14'b00100000000000,
        ST_DONE   = 14'b01000000000000,
        ST_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        abs_en_reg,    abs_en_next;
    logic        tcs_en_reg,    tcs_en_next;
    logic [30:0] radius_reg,    radius_next;
    logic [30:0] dt_reg,        dt_next;
    logic [30:0] inertia_reg,   inertia_next;
    logic [30:0] max_torq_reg,  max_torq_next;

    // state kept between ticks
    logic signed [31:0] prev_reg, prev_next;
    logic               abs_flag_reg, abs_flag_next;
    logic               tcs_flag_reg, tcs_flag_next;

    // per-tick control
    logic abs_go_reg, abs_go_next;
    logic tcs_go_reg, tcs_go_next;

    // latched word and working registers
    logic signed [31:0] torque_reg, torque_next;
    logic signed [31:0] slip_reg,   slip_next;
    logic [30:0]        ideal_reg,  ideal_next;
    logic signed [31:0] vg_reg,     vg_next;
    logic signed [31:0] w_reg,      w_next;
    logic [16:0]        cur_reg,    cur_next;
    logic signed [33:0] pred_reg,   pred_next;
    logic signed [63:0] quo_s_reg,  quo_s_next;
    logic signed [31:0] err_sat_reg, err_sat_next;
    logic signed [63:0] t_reg,      t_next;
    logic [16:0]        fac_reg,    fac_next;
    logic               sign_reg,   sign_next;

    // shared units
    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    // helpers
    logic               cfg_wr;
    logic [31:0]        ideal_rnd;
    logic [29:0]        q5;
    logic [31:0]        gain32;
    logic [PROD_W-1:0]  prod_mag;
    logic [63:0]        q_mag;
    logic signed [63:0] q_signed;
    logic signed [63:0] err_full;
    logic signed [31:0] err_clip;
    logic signed [32:0] slip_x;
    logic signed [32:0] ideal_x;
    logic signed [32:0] slip_sum;
    logic signed [32:0] slip_diff;
    logic               slip_lo;
    logic               slip_hi;
    logic               torque_ok;
    logic               speed_ok;
    logic [30:0]        radius_nz;
    logic [30:0]        dt_nz;
    logic [30:0]        maxt_nz;
    logic               t_le0;
    logic               t_ge_max;
    logic               t_ge_2max;
    logic [16:0]        q17;
    logic [16:0]        fac_tcs;

    abstcs_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    abstcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // apb configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        case (paddr[4:2])
            REG_ABS_EN:    prdata = {31'd0, abs_en_reg};
            REG_TCS_EN:    prdata = {31'd0, tcs_en_reg};
            REG_RADIUS:    prdata = {1'b0, radius_reg};
            REG_TIME_STEP: prdata = {1'b0, dt_reg};
            REG_INERTIA:   prdata = {1'b0, inertia_reg};
            REG_MAX_TORQ:  prdata = {1'b0, max_torq_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        abs_en_next   = abs_en_reg;
        tcs_en_next   = tcs_en_reg;
        radius_next   = radius_reg;
        dt_next       = dt_reg;
        inertia_next  = inertia_reg;
        max_torq_next = max_torq_reg;
        if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ABS_EN:    abs_en_next   = pwdata[0];
                REG_TCS_EN:    tcs_en_next   = pwdata[0];
                REG_RADIUS:    radius_next   = pwdata[30:0];
                REG_TIME_STEP: dt_next       = pwdata[30:0];
                REG_INERTIA:   inertia_next  = pwdata[30:0];
                REG_MAX_TORQ:  max_torq_next = pwdata[30:0];
                default:       abs_en_next   = abs_en_reg;
            endcase
        end
    end

    // zero divisors count as one lsb
    assign radius_nz = (radius_reg == '0)   ? 31'd1 : radius_reg;
    assign dt_nz     = (dt_reg == '0)       ? 31'd1 : dt_reg;
    assign maxt_nz   = (max_torq_reg == '0) ? 31'd1 : max_torq_reg;

    // 0.95*ideal = ideal - ceil(ideal/20); ceil via (ideal+19)/4/5
    assign ideal_rnd = {1'b0, ideal_reg} + {27'd0, GAIN_ROUND};
    assign q5        = mul_prod[RECIP_SHIFT+29:RECIP_SHIFT];
    assign gain32    = {1'b0, ideal_reg} + {15'd0, GAIN_OFFSET} - {2'b00, q5};

    // magnitude and signed quotient around the unsigned divider
    assign prod_mag = mul_prod[PROD_W-1] ? PROD_W'(-mul_prod) : PROD_W'(mul_prod);
    assign q_mag    = {2'b00, div_rsp.quotient[MAG_W-1:0]};
    assign q_signed = sign_reg ? -$signed(q_mag) : $signed(q_mag);

    // speed error and its saturation to 32 bits
    assign err_full = {{30{pred_reg[33]}}, pred_reg} - quo_s_reg;
    always_comb
    begin
        if ((&err_full[63:31]) || !(|err_full[63:31]))
        begin
            err_clip = err_full[31:0];
        end
        else if (err_full[63])
        begin
            err_clip = 32'sh80000000;
        end
        else
        begin
            err_clip = 32'sh7FFFFFFF;
        end
    end

    // slip, torque and speed qualifiers
    assign slip_x    = {slip_reg[31], slip_reg};
    assign ideal_x   = {2'b00, ideal_reg};
    assign slip_sum  = slip_x + ideal_x;
    assign slip_diff = slip_x - ideal_x;
    assign slip_lo   = slip_sum[32];
    assign slip_hi   = !slip_diff[32] && (slip_diff != '0);
    assign torque_ok = torque_reg > TORQUE_EPS;
    assign speed_ok  = (vg_reg > SPEED_MIN) || (vg_reg < -SPEED_MIN);

    // corrected torque against the brake limit
    assign t_le0     = t_reg[63] || (t_reg == '0);
    assign t_ge_max  = !t_reg[63] && ($unsigned(t_reg) >= {33'd0, maxt_nz});
    assign t_ge_2max = !t_reg[63] && ($unsigned(t_reg) >= {32'd0, maxt_nz, 1'b0});

    // tcs clamp: the present factor when the quotient is below it, else the quotient capped at one
    assign q17 = div_rsp.quotient[FAC_W-1:0];
    always_comb
    begin
        if (q17 < cur_reg)
        begin
            fac_tcs = cur_reg;
        end
        else if (q17 > ONE_Q16)
        begin
            fac_tcs = ONE_Q16;
        end
        else
        begin
            fac_tcs = q17;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_RECIP:
            begin
                mul_en = 1'b1;
                mul_a  = {3'b000, ideal_rnd[31:2]};
                mul_b  = RECIP_5;
            end
            ST_GAIN:
            begin
                mul_en = 1'b1;
                mul_a  = {2'b00, gain32[30:0]};
                mul_b  = {vg_reg[31], vg_reg};
            end
            ST_CMUL:
            begin
                mul_en = 1'b1;
                mul_a  = {err_sat_reg[31], err_sat_reg};
                mul_b  = {2'b00, inertia_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        prev_next     = prev_reg;
        abs_flag_next = abs_flag_reg;
        tcs_flag_next = tcs_flag_reg;
        abs_go_next   = abs_go_reg;
        tcs_go_next   = tcs_go_reg;
        torque_next   = torque_reg;
        slip_next     = slip_reg;
        ideal_next    = ideal_reg;
        vg_next       = vg_reg;
        w_next        = w_reg;
        cur_next      = cur_reg;
        pred_next     = pred_reg;
        quo_s_next    = quo_s_reg;
        err_sat_next  = err_sat_reg;
        t_next        = t_reg;
        fac_next      = fac_reg;
        sign_next     = sign_reg;
        div_req       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    torque_next = item.requested_torque;
                    slip_next   = item.slip_ratio;
                    ideal_next  = item.ideal_slip;
                    vg_next     = item.ground_speed;
                    w_next      = item.wheel_speed;
                    cur_next    = item.brake_factor_now;
                    fac_next    = item.brake_factor_now;
                    state_next  = item.in_contact ? ST_RECIP : ST_OUT;
                end
            end
            ST_RECIP:
            begin
                // predicted speed 2*w - previous
                pred_next  = {w_reg[31], w_reg, 1'b0} - {{2{prev_reg[31]}}, prev_reg};
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_TSTART;
            end
            ST_TSTART:
            begin
                // target speed = gain * ground speed / radius
                sign_next        = mul_prod[PROD_W-1];
                div_req.start    = 1'b1;
                div_req.rem_init = '0;
                div_req.quo_init = {prod_mag[MAG_W-1:0], 2'b00};
                div_req.divisor  = radius_nz;
                div_req.steps    = STEPS_WIDE;
                state_next       = ST_TDIV;
            end
            ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    quo_s_next = q_signed;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_sat_next = err_clip;
                abs_go_next  = abs_en_reg && torque_ok && speed_ok && slip_lo
                               && err_full[63];
                tcs_go_next  = tcs_en_reg && slip_hi && !err_full[63]
                               && (err_full != '0);
                if ((abs_en_reg && torque_ok && speed_ok && slip_lo && err_full[63])
                    || (tcs_en_reg && slip_hi && !err_full[63] && (err_full != '0)))
                begin
                    state_next = ST_CMUL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMUL:
            begin
                state_next = ST_CSTART;
            end
            ST_CSTART:
            begin
                // torque correction = err * inertia / time step
                sign_next        = mul_prod[PROD_W-1];
                div_req.start    = 1'b1;
                div_req.rem_init = '0;
                div_req.quo_init = {prod_mag[MAG_W-1:0], 2'b00};
                div_req.divisor  = dt_nz;
                div_req.steps    = STEPS_WIDE;
                state_next       = ST_CDIV;
            end
            ST_CDIV:
            begin
                if (div_rsp.done)
                begin
                    quo_s_next = q_signed;
                    state_next = ST_TORQ;
                end
            end
            ST_TORQ:
            begin
                if (abs_go_reg)
                begin
                    t_next = {{32{torque_reg[31]}}, torque_reg} + quo_s_reg;
                end
                else
                begin
                    t_next = quo_s_reg;
                end
                state_next = ST_FSEL;
            end
            ST_FSEL:
            begin
                // factor = torque * 65536 / max torque, preset for 17 steps
                div_req.rem_init = t_reg[31:1];
                div_req.quo_init = {t_reg[0], 63'd0};
                div_req.divisor  = maxt_nz;
                div_req.steps    = STEPS_FAC;
                if (abs_go_reg)
                begin
                    if (t_le0)
                    begin
                        fac_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (t_ge_max)
                    begin
                        fac_next   = ONE_Q16;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_FDIV;
                    end
                end
                else
                begin
                    if (t_ge_2max)
                    begin
                        fac_next   = ONE_Q16;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_FDIV;
                    end
                end
            end
            ST_FDIV:
            begin
                if (div_rsp.done)
                begin
                    fac_next   = abs_go_reg ? q17 : fac_tcs;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                abs_flag_next = abs_go_reg;
                tcs_flag_next = tcs_go_reg;
                prev_next     = w_reg;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            abs_en_reg   <= 1'b0;
            tcs_en_reg   <= 1'b0;
            radius_reg   <= 31'd19661;
            dt_reg       <= 31'd1092;
            inertia_reg  <= 31'd65536;
            max_torq_reg <= 31'd65536000;
            prev_reg     <= '0;
            abs_flag_reg <= 1'b0;
            tcs_flag_reg <= 1'b0;
            abs_go_reg   <= 1'b0;
            tcs_go_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            abs_en_reg   <= abs_en_next;
            tcs_en_reg   <= tcs_en_next;
            radius_reg   <= radius_next;
            dt_reg       <= dt_next;
            inertia_reg  <= inertia_next;
            max_torq_reg <= max_torq_next;
            prev_reg     <= prev_next;
            abs_flag_reg <= abs_flag_next;
            tcs_flag_reg <= tcs_flag_next;
            abs_go_reg   <= abs_go_next;
            tcs_go_reg   <= tcs_go_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        torque_reg  <= torque_next;
        slip_reg    <= slip_next;
        ideal_reg   <= ideal_next;
        vg_reg      <= vg_next;
        w_reg       <= w_next;
        cur_reg     <= cur_next;
        pred_reg    <= pred_next;
        quo_s_reg   <= quo_s_next;
        err_sat_reg <= err_sat_next;
        t_reg       <= t_next;
        fac_reg     <= fac_next;
        sign_reg    <= sign_next;
    end

    // channels
    assign item.ready          = (state_reg == ST_IDLE);
    assign result.valid        = (state_reg == ST_OUT);
    assign result.brake_factor = fac_reg;
    assign result.abs_engaged  = abs_flag_reg;
    assign result.tcs_engaged  = tcs_flag_reg;

    // a taken word keeps the block busy for at least the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item taken while previous word still in work");

    // abs and tcs need opposite error signs, so never both
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.abs_engaged && result.tcs_engaged))
        else $error("abs and tcs active together");

    // a stalled result word holds until taken
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready)
        |=> (result.valid && $stable(result.brake_factor)))
        else $error("result word changed while stalled");

    // divider is started only from a state that waits for it
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> ((state_reg == ST_TDIV) || (state_reg == ST_CDIV)
                           || (state_reg == ST_FDIV)))
        else $error("divider started without a wait state");

endmodule

// ===== src/abstcs_mul.sv =====
// ----------------------------------------------------------------------------
// abstcs_mul
// shared signed multiplier, product registered, loads only when enabled
// ----------------------------------------------------------------------------
module abstcs_mul (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [abstcs_pkg::MUL_W-1:0]    a,
    input  logic signed [abstcs_pkg::MUL_W-1:0]    b,
    output logic signed [abstcs_pkg::PROD_W-1:0]   prod
);
    import abstcs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // full-width signed product
    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/abstcs_div.sv =====
// ----------------------------------------------------------------------------
// abstcs_div
// shared restoring divider, one quotient bit per cycle; the caller presets the
// partial remainder and the dividend bits still to shift in, and the count
// ----------------------------------------------------------------------------
module abstcs_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  abstcs_pkg::div_req_t  req,
    output abstcs_pkg::div_rsp_t  rsp
);
    import abstcs_pkg::*;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] cnt_reg,   cnt_next;
    logic [DVS_W-1:0]  rem_reg,   rem_next;
    logic [QUO_W-1:0]  quo_reg,   quo_next;
    logic [DVS_W-1:0]  dvs_reg,   dvs_next;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W+1:0]  diff;

    // trial subtract of one shifted-in dividend bit
    assign rem_sh = {rem_reg, quo_reg[QUO_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            quo_next  = req.quo_init;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_W+1])
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench of the abs/tcs brake factor controller: a table of directed
// ticks, then random wheel ticks under several register settings and
// idle/stall mixes; every result word is checked against the row's typed result
// or a local regulator model that tracks the wheel speed history and the held flags
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import abstcs_pkg::*;

    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     DRAIN_WAIT  = 200;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = -64'sd2147483648;

    // one wheel tick and the word it should produce
    typedef struct packed {
        logic               contact;
        logic signed [31:0] torque;
        logic signed [31:0] slip;
        logic [30:0]        ideal;
        logic signed [31:0] ground;
        logic signed [31:0] wspeed;
        logic [16:0]        factor_now;
    } tick_t;

    typedef struct packed {
        logic [16:0] factor;
        logic        abs_on;
        logic        tcs_on;
    } verdict_t;

    // one full register setting
    typedef struct packed {
        logic        abs_en;
        logic        tcs_en;
        logic [30:0] radius;
        logic [30:0] step;
        logic [30:0] inertia;
        logic [30:0] max_torque;
    } cal_t;

    // directed row: setting, tick, and a typed result where it is obvious
    typedef struct {
        int       cal;
        tick_t    tick;
        bit       typed;
        verdict_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        sink_ready = 1'b0;

    abstcs_item_if   tick_bus ();
    abstcs_result_if factor_bus ();

    assign factor_bus.ready = sink_ready;

    abs_tcs_brake_factor_controller_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (tick_bus),
        .result  (factor_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state and settings
    cal_t      cal_sets [6];
    cal_t      model_cal;
    int        cur_cal = 0;
    longint    last_wspeed = 0;
    bit        abs_held = 1'b0;
    bit        tcs_held = 1'b0;
    verdict_t  pending [$];
    plan_row_t plan [$];
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        err_cnt = 0;
    int        cycles = 0;
    bit        offering = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        sink_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    function automatic longint at_least_one(input longint v);
        return (v == 0) ? 64'sd1 : v;
    endfunction

    // regulator model: one tick in, one verdict out, updates held state
    function automatic verdict_t regulate(input tick_t t);
        longint one, maxt, pred, gain, target, err, errs, corr, trq, f, factor;
        longint ideal, ground, slip, mag;
        verdict_t v;
        one    = longint'(ONE_Q16);
        factor = longint'(t.factor_now);
        if (t.contact)
        begin
            ideal  = longint'(t.ideal);
            ground = longint'($signed(t.ground));
            slip   = longint'($signed(t.slip));
            trq    = longint'($signed(t.torque));
            maxt   = at_least_one(longint'(model_cal.max_torque));
            pred   = 2 * longint'($signed(t.wspeed)) - last_wspeed;
            gain   = (ideal * 19) / 20 + one;
            target = (gain * ground) / at_least_one(longint'(model_cal.radius));
            err    = pred - target;
            mag    = (ground < 0) ? -ground : ground;
            errs   = (err > S32_MAX) ? S32_MAX : ((err < S32_MIN) ? S32_MIN : err);
            corr   = (errs * longint'(model_cal.inertia)) /
                     at_least_one(longint'(model_cal.step));
            abs_held = 1'b0;
            tcs_held = 1'b0;

            // anti-lock: braking with the wheel slower than the target
            if (model_cal.abs_en && trq > longint'(TORQUE_EPS) &&
                mag > longint'(SPEED_MIN) && slip < -ideal && err < 0)
            begin
                trq = trq + corr;
                if (trq <= 0)
                    factor = 0;
                else if (trq >= maxt)
                    factor = one;
                else
                    factor = (trq * one) / maxt;
                abs_held = 1'b1;
            end

            // traction control: wheel spinning, factor takes the quotient, capped at one, if not below it
            if (model_cal.tcs_en && slip > ideal && err > 0)
            begin
                if (corr >= 2 * maxt)
                    f = 2 * one;
                else
                    f = (corr * one) / maxt;
                if (f >= factor)
                    factor = (f > one) ? one : f;
                tcs_held = 1'b1;
            end

            last_wspeed = longint'($signed(t.wspeed));
        end
        v.factor = factor[16:0];
        v.abs_on = abs_held;
        v.tcs_on = tcs_held;
        return v;
    endfunction

    // random tick: mostly plausible driving, some raw noise
    function automatic tick_t draw_tick();
        tick_t  t;
        longint ideal, g, gain, tgt, w, s;
        if ($urandom_range(99) < 25)
        begin
            t.contact    = 1'($urandom_range(1));
            t.torque     = $urandom;
            t.slip       = $urandom;
            t.ideal      = 31'($urandom);
            t.ground     = $urandom;
            t.wspeed     = $urandom;
            t.factor_now = 17'($urandom);
            return t;
        end
        t.contact = ($urandom_range(19) != 0);
        ideal     = longint'($urandom_range(26214, 1311));
        t.ideal   = ideal[30:0];
        g         = longint'($urandom_range(3932160, 131072));
        if ($urandom_range(1))
            g = -g;
        t.ground  = g[31:0];
        gain      = (ideal * 19) / 20 + longint'(ONE_Q16);
        tgt       = (gain * g) / at_least_one(longint'(model_cal.radius));
        tgt       = (tgt > 64'sd1073741823) ? 64'sd1073741823 :
                    ((tgt < -64'sd1073741823) ? -64'sd1073741823 : tgt);
        case ($urandom_range(3))
            0:       w = tgt / 4;
            1:       w = tgt * 2;
            default: w = tgt + longint'($urandom_range(2621440)) - 64'sd1310720;
        endcase
        t.wspeed  = w[31:0];
        case ($urandom_range(2))
            0:       s = -ideal - longint'($urandom_range(65536, 1));
            1:       s = ideal + longint'($urandom_range(65536, 1));
            default: s = longint'($urandom_range(32'(2 * ideal))) - ideal;
        endcase
        t.slip       = s[31:0];
        t.torque     = $urandom_range(32'h7fffffff) >> $urandom_range(20);
        t.factor_now = 17'($urandom_range(65536));
        return t;
    endfunction

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin : watch_results
        verdict_t want;
        if (rst_n && factor_bus.valid && factor_bus.ready)
        begin
            if (pending.size() == 0)
            begin
                $error("unexpected result word: brake_factor %0d",
                       factor_bus.brake_factor);
                err_cnt++;
            end
            else
            begin
                want = pending.pop_front();
                if (factor_bus.brake_factor !== want.factor)
                begin
                    $error("brake_factor: expected %0d, got %0d",
                           want.factor, factor_bus.brake_factor);
                    err_cnt++;
                end
                if (factor_bus.abs_engaged !== want.abs_on)
                begin
                    $error("abs_engaged: expected %0d, got %0d",
                           want.abs_on, factor_bus.abs_engaged);
                    err_cnt++;
                end
                if (factor_bus.tcs_engaged !== want.tcs_on)
                begin
                    $error("tcs_engaged: expected %0d, got %0d",
                           want.tcs_on, factor_bus.tcs_engaged);
                    err_cnt++;
                end
            end
        end
    end

    // offer one tick word, idling first at the current rate
    task automatic push_tick(input tick_t t, input bit typed, input verdict_t fixed);
        verdict_t v;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            if (offering)
            begin
                tick_bus.valid <= 1'b0;
                offering = 1'b0;
            end
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        tick_bus.valid            <= 1'b1;
        offering                   = 1'b1;
        tick_bus.in_contact       <= t.contact;
        tick_bus.requested_torque <= t.torque;
        tick_bus.slip_ratio       <= t.slip;
        tick_bus.ideal_slip       <= t.ideal;
        tick_bus.ground_speed     <= t.ground;
        tick_bus.wheel_speed      <= t.wspeed;
        tick_bus.brake_factor_now <= t.factor_now;
        do @(posedge clk); while (!tick_bus.ready);
        v = regulate(t);
        pending.push_back(typed ? fixed : v);
    endtask

    // stop offering and wait for every outstanding word
    task automatic settle();
        if (offering)
        begin
            tick_bus.valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    // apb write: setup then access; psel stays up for back-to-back writes
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic apply_cal(input int k);
        settle();
        write_reg(REG_ABS_EN, 32'(cal_sets[k].abs_en));
        write_reg(REG_TCS_EN, 32'(cal_sets[k].tcs_en));
        write_reg(REG_RADIUS, 32'(cal_sets[k].radius));
        write_reg(REG_TIME_STEP, 32'(cal_sets[k].step));
        write_reg(REG_INERTIA, 32'(cal_sets[k].inertia));
        write_reg(REG_MAX_TORQ, 32'(cal_sets[k].max_torque));
        psel    <= 1'b0;
        penable <= 1'b0;
        model_cal = cal_sets[k];
        cur_cal   = k;
    endtask

    function automatic void add_row(input int cal, input logic contact,
                                    input logic [31:0] torque, input logic [31:0] slip,
                                    input logic [30:0] ideal, input logic [31:0] ground,
                                    input logic [31:0] wspeed, input logic [16:0] fnow,
                                    input bit typed, input logic [16:0] wf,
                                    input logic wa, input logic wt);
        plan_row_t r;
        r.cal  = cal;
        r.tick = {contact, torque, slip, ideal, ground, wspeed, fnow};
        r.typed = typed;
        r.want = {wf, wa, wt};
        plan.push_back(r);
    endfunction

    task automatic run_random(input int cal, input int gap, input int stall,
                              input int count);
        tick_t    t;
        verdict_t none;
        none = '0;
        if (cal != cur_cal)
            apply_cal(cal);
        gap_pct   = gap;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            t = draw_tick();
            push_tick(t, 1'b0, none);
            // occasional full drain mid-phase
            if (n == count / 2 || $urandom_range(63) == 0)
                settle();
        end
    endtask

    initial
    begin
        // drive every input from time zero
        tick_bus.valid            <= 1'b0;
        tick_bus.in_contact       <= 1'b0;
        tick_bus.requested_torque <= '0;
        tick_bus.slip_ratio       <= '0;
        tick_bus.ideal_slip       <= '0;
        tick_bus.ground_speed     <= '0;
        tick_bus.wheel_speed      <= '0;
        tick_bus.brake_factor_now <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        // register settings: reset values, enabled defaults, zero divisors,
        // abs only, tcs with top values, bottom values
        cal_sets[0] = {1'b0, 1'b0, 31'd19661, 31'd1092, 31'd65536, 31'd65536000};
        cal_sets[1] = {1'b1, 1'b1, 31'd19661, 31'd1092, 31'd65536, 31'd65536000};
        cal_sets[2] = {1'b1, 1'b1, 31'd0, 31'd0, 31'd65536, 31'd0};
        cal_sets[3] = {1'b1, 1'b0, 31'd65536, 31'd655, 31'd131072, 31'd131072000};
        cal_sets[4] = {1'b0, 1'b1, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                       31'h7fffffff};
        cal_sets[5] = {1'b1, 1'b1, 31'd1, 31'd1, 31'd0, 31'd1};
        model_cal = cal_sets[0];

        // cal contact torque slip ideal ground wspeed fnow | typed f abs tcs
        // controller off: factor passes through, flags low
        add_row(0, 1'b0, 0, 0, 0, 0, 0, 0,                              1, 0, 0, 0);
        add_row(0, 1'b0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h7fffffff,
                32'h80000000, 65536,                                     1, 65536, 0, 0);
        add_row(0, 1'b1, 32'h80000000, 32'h7fffffff, 0, 32'h80000000,
                32'h7fffffff, 12345,                                     1, 12345, 0, 0);
        add_row(0, 1'b1, 0, 0, 0, 0, 0, 1,                              1, 1, 0, 0);
        // anti-lock: locked wheel, clamp to zero, to one, mid value
        add_row(1, 1'b1, 32768000, -32768, 13107, 1310720, 655360, 40000, 0, 0, 0, 0);
        add_row(1, 1'b1, 32'h7fffffff, -32768, 13107, 1310720, 655360, 40000,
                0, 0, 0, 0);
        add_row(1, 1'b1, 327680000, -32768, 13107, 1310720, 655360, 40000,
                0, 0, 0, 0);
        // torque and speed thresholds, slip on the boundary
        add_row(1, 1'b1, 65, -32768, 13107, 1310720, 655360, 777,     0, 0, 0, 0);
        add_row(1, 1'b1, 66, -32768, 13107, 1310720, 655360, 777,     0, 0, 0, 0);
        add_row(1, 1'b1, 32768000, -32768, 13107, 196608, 655360, 777, 0, 0, 0, 0);
        add_row(1, 1'b1, 32768000, -32768, 13107, -196609, -655360, 777,
                0, 0, 0, 0);
        add_row(1, 1'b1, 32768000, -13107, 13107, 1310720, 655360, 777, 0, 0, 0, 0);
        // traction control: spin, factor above one kept, factor raised
        add_row(1, 1'b1, 0, 32768, 13107, 1310720, 13107200, 500,     0, 0, 0, 0);
        add_row(1, 1'b1, 0, 32768, 13107, 1310720, 5242880, 500,      0, 0, 0, 0);
        add_row(1, 1'b1, 0, 32768, 13107, 1310720, 5242880, 131071,   0, 0, 0, 0);
        add_row(1, 1'b1, 0, 32768, 13107, 1310720, 5242880, 100,      0, 0, 0, 0);
        // no contact keeps the held flags
        add_row(1, 1'b0, 0, 0, 0, 0, 32'h12345678, 99,                0, 0, 0, 0);
        // zero divisors behave as one lsb
        add_row(2, 1'b1, 32768000, -32768, 13107, 1310720, 655360, 300, 0, 0, 0, 0);
        add_row(2, 1'b1, 0, 32768, 13107, -1310720, 655360, 300,      0, 0, 0, 0);
        add_row(2, 1'b0, 5, 5, 5, 5, 5, 65535,                        0, 0, 0, 0);
        // bottom register values, zero inertia
        add_row(5, 1'b1, 32768000, -32768, 13107, 1310720, 0, 20000,  0, 0, 0, 0);
        add_row(5, 1'b1, 0, 32768, 13107, -1310720, 655360, 20000,    0, 0, 0, 0);

        // hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].cal != cur_cal)
                apply_cal(plan[i].cal);
            push_tick(plan[i].tick, plan[i].typed, plan[i].want);
        end

        // random phases over settings and idle/stall mixes
        run_random(1, 0, 0, 100);
        run_random(3, 57, 0, 70);
        run_random(4, 0, 57, 50);
        run_random(2, 33, 33, 50);
        run_random(5, 57, 0, 40);
        run_random(1, 33, 33, 90);

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0 && pending.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
